### design/hbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbe_pkg
// Shared constants, item types and helpers of the histogram binning engine.
// ----------------------------------------------------------------------------
package hbe_pkg;

  localparam int MAX_BINS     = 1024;
  localparam int COUNT_WIDTH  = 32;
  localparam int SAMPLE_WIDTH = 32;

  localparam int BIN_AW = $clog2(MAX_BINS);
  localparam int NBIN_W = $clog2(MAX_BINS + 1);
  localparam int STEP_W = $clog2(NBIN_W);

  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int IDX_W     = 10;
  localparam int CFG_BIN_W = 11;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_BINNED = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_UNDER  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_OVER   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_READ   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_CLEAR  = 3'd4;

  localparam logic [1:0] REG_LOW  = 2'd0;
  localparam logic [1:0] REG_HIGH = 2'd1;
  localparam logic [1:0] REG_BINS = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]               cmd;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [IDX_W-1:0]               read_index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [IDX_W-1:0]       bin_number;
    logic [COUNT_WIDTH-1:0] bin_count;
    logic [COUNT_WIDTH-1:0] underflow_count;
    logic [COUNT_WIDTH-1:0] overflow_count;
  } out_item_t;

  typedef struct packed {
    logic                   we;
    logic [BIN_AW-1:0]      addr;
    logic [COUNT_WIDTH-1:0] data;
  } ram_wr_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CLASSIFY,
    S_DIVIDE,
    S_READ,
    S_UPDATE,
    S_FINISH
  } state_e;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

endpackage

### design/histogram_binning_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_binning_engine_top
// Uniform-bin histogram of signed samples with saturating counts.
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_ready_o carries one command item: add sample,
// read bin or clear. Each add, read or clear item gives exactly one result
// item on out_valid_o/out_ready_i; command code 3 is dropped with no result.
// Limits and bin count are to be written over the APB port only while the
// block is idle, which the block does not enforce. One item at a time is
// worked on; steps from accept to result valid:
//   add, underflow or overflow:  classify, then finish
//   add, binned sample:          classify, the serial bin index unit, then a
//                                read-modify-write of the bin store, finish
//   read bin:                    read of the bin store, then finish
//   clear:                       all 1024 store entries zeroed, one per cycle
// The next item is accepted once a result enters the output register.
// After reset all 1024 store entries are swept to zero, during which
// in_ready_o stays low; configuration writes are taken at any time.
// A result waits in the output register while the receiver stalls; the block
// still accepts the next item and holds its result until the register frees.
// ----------------------------------------------------------------------------
module histogram_binning_engine_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  hbe_pkg::in_item_t                  in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output hbe_pkg::out_item_t                 out_item_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hbe_pkg::PADDR_W-1:0]        paddr,
  input  logic [hbe_pkg::PDATA_W-1:0]        pwdata,
  output logic [hbe_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int W  = hbe_pkg::SAMPLE_WIDTH;
  localparam int CW = hbe_pkg::COUNT_WIDTH;
  localparam logic [W-1:0] SIGN_FLIP = {1'b1, {(W - 1){1'b0}}};

  logic [W-1:0]                    low_q, high_q;
  logic [hbe_pkg::CFG_BIN_W-1:0]   bins_q;
  logic                            cfg_wr;

  hbe_pkg::state_e                 state_q, state_d;
  hbe_pkg::in_item_t               item_q, item_d;
  hbe_pkg::out_item_t              res_q, res_d;
  hbe_pkg::out_item_t              out_q, out_d;
  logic                            out_valid_q, out_valid_d;
  logic [CW-1:0]                   under_q, under_d;
  logic [CW-1:0]                   over_q, over_d;
  logic [hbe_pkg::BIN_AW-1:0]      clr_cnt_q, clr_cnt_d;
  logic                            clr_report_q, clr_report_d;
  logic [hbe_pkg::BIN_AW-1:0]      idx_q, idx_d;

  logic [W-1:0]                    lim_a, lim_b, lo_b, hi_b, v_b;
  logic [W-1:0]                    dividend, span;
  logic [hbe_pkg::NBIN_W-1:0]      n_eff, n_m1;
  logic                            div_start, div_done;
  logic [hbe_pkg::NBIN_W-1:0]      div_quot;
  hbe_pkg::ram_wr_t                ram_wr;
  logic [hbe_pkg::BIN_AW-1:0]      ram_raddr;
  logic [CW-1:0]                   ram_rdata;
  logic [CW-1:0]                   cnt_new;

  // configuration port
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '0;
      bins_q <= hbe_pkg::CFG_BIN_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        hbe_pkg::REG_LOW:  low_q  <= pwdata[W-1:0];
        hbe_pkg::REG_HIGH: high_q <= pwdata[W-1:0];
        hbe_pkg::REG_BINS: bins_q <= pwdata[hbe_pkg::CFG_BIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      hbe_pkg::REG_LOW:  prdata = low_q;
      hbe_pkg::REG_HIGH: prdata = high_q;
      hbe_pkg::REG_BINS: prdata = hbe_pkg::PDATA_W'(bins_q);
      default:           prdata = '0;
    endcase
  end

  // range and bin count
  always_comb begin
    lim_a    = low_q ^ SIGN_FLIP;
    lim_b    = high_q ^ SIGN_FLIP;
    lo_b     = (lim_a < lim_b) ? lim_a : lim_b;
    hi_b     = (lim_a < lim_b) ? lim_b : lim_a;
    v_b      = item_q.sample ^ SIGN_FLIP;
    dividend = v_b - lo_b;
    span     = hi_b - lo_b;
    if (bins_q == '0) begin
      n_eff = hbe_pkg::NBIN_W'(1);
    end else if (bins_q > hbe_pkg::CFG_BIN_W'(hbe_pkg::MAX_BINS)) begin
      n_eff = hbe_pkg::NBIN_W'(hbe_pkg::MAX_BINS);
    end else begin
      n_eff = hbe_pkg::NBIN_W'(bins_q);
    end
    n_m1    = n_eff - 1'b1;
    cnt_new = hbe_pkg::sat_inc(ram_rdata);
  end

  hbe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .span_i     (span),
    .bins_i     (n_eff),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  hbe_bin_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (ram_wr),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    under_d      = under_q;
    over_d       = over_q;
    clr_cnt_d    = clr_cnt_q;
    clr_report_d = clr_report_q;
    idx_d        = idx_q;
    div_start    = 1'b0;
    ram_wr       = '0;
    ram_raddr    = idx_q;
    in_ready_o   = 1'b0;

    unique case (state_q)
      hbe_pkg::S_CLEAR: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = clr_cnt_q;
        clr_cnt_d   = clr_cnt_q + 1'b1;
        if (clr_cnt_q == hbe_pkg::BIN_AW'(hbe_pkg::MAX_BINS - 1)) begin
          under_d      = '0;
          over_d       = '0;
          clr_report_d = 1'b0;
          if (clr_report_q) begin
            res_d            = '0;
            res_d.status     = hbe_pkg::STAT_CLEAR;
            state_d          = hbe_pkg::S_FINISH;
          end else begin
            state_d = hbe_pkg::S_IDLE;
          end
        end
      end
      hbe_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d = in_item_i;
          case (in_item_i.cmd)
            hbe_pkg::CMD_ADD:  state_d = hbe_pkg::S_CLASSIFY;
            hbe_pkg::CMD_READ: state_d = hbe_pkg::S_READ;
            hbe_pkg::CMD_CLEAR: begin
              clr_cnt_d    = '0;
              clr_report_d = 1'b1;
              state_d      = hbe_pkg::S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      hbe_pkg::S_CLASSIFY: begin
        res_d = '0;
        if (v_b < lo_b) begin
          under_d      = hbe_pkg::sat_inc(under_q);
          res_d.status = hbe_pkg::STAT_UNDER;
          state_d      = hbe_pkg::S_FINISH;
        end else if (v_b >= hi_b) begin
          over_d       = hbe_pkg::sat_inc(over_q);
          res_d.status = hbe_pkg::STAT_OVER;
          state_d      = hbe_pkg::S_FINISH;
        end else begin
          div_start = 1'b1;
          state_d   = hbe_pkg::S_DIVIDE;
        end
      end
      hbe_pkg::S_DIVIDE: begin
        if (div_done) begin
          idx_d   = (div_quot >= n_eff) ? n_m1[hbe_pkg::BIN_AW-1:0]
                                        : div_quot[hbe_pkg::BIN_AW-1:0];
          state_d = hbe_pkg::S_READ;
        end
      end
      hbe_pkg::S_READ: begin
        if (item_q.cmd == hbe_pkg::CMD_ADD) begin
          ram_raddr = idx_q;
        end else begin
          ram_raddr = item_q.read_index;
        end
        state_d = hbe_pkg::S_UPDATE;
      end
      hbe_pkg::S_UPDATE: begin
        res_d = '0;
        if (item_q.cmd == hbe_pkg::CMD_ADD) begin
          ram_wr.we        = 1'b1;
          ram_wr.addr      = idx_q;
          ram_wr.data      = cnt_new;
          res_d.status     = hbe_pkg::STAT_BINNED;
          res_d.bin_number = idx_q;
          res_d.bin_count  = cnt_new;
        end else begin
          res_d.status     = hbe_pkg::STAT_READ;
          res_d.bin_number = item_q.read_index;
          res_d.bin_count  = ram_rdata;
        end
        state_d = hbe_pkg::S_FINISH;
      end
      hbe_pkg::S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d                 = res_q;
          out_d.underflow_count = under_q;
          out_d.overflow_count  = over_q;
          out_valid_d           = 1'b1;
          state_d               = hbe_pkg::S_IDLE;
        end
      end
      default: state_d = hbe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= hbe_pkg::S_CLEAR;
      out_valid_q  <= 1'b0;
      under_q      <= '0;
      over_q       <= '0;
      clr_cnt_q    <= '0;
      clr_report_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      under_q      <= under_d;
      over_q       <= over_d;
      clr_cnt_q    <= clr_cnt_d;
      clr_report_q <= clr_report_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
    idx_q  <= idx_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### design/hbe_bin_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbe_bin_ram
// Bin count store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hbe_bin_ram (
  input  logic                                clk_i,
  input  hbe_pkg::ram_wr_t                    wr_i,
  input  logic [hbe_pkg::BIN_AW-1:0]          raddr_i,
  output logic [hbe_pkg::COUNT_WIDTH-1:0]     rdata_o
);

  logic [hbe_pkg::COUNT_WIDTH-1:0] mem [hbe_pkg::MAX_BINS];
  logic [hbe_pkg::COUNT_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/hbe_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbe_div
// Serial restoring unit for floor(d * n / w), with d < w. Two half steps per
// bit of n: double the partial remainder, then add d where the bit is set.
// ----------------------------------------------------------------------------
module hbe_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [hbe_pkg::SAMPLE_WIDTH-1:0]  dividend_i,
  input  logic [hbe_pkg::SAMPLE_WIDTH-1:0]  span_i,
  input  logic [hbe_pkg::NBIN_W-1:0]        bins_i,
  output logic                              done_o,
  output logic [hbe_pkg::NBIN_W-1:0]        quot_o
);

  localparam int W = hbe_pkg::SAMPLE_WIDTH;

  logic                             busy_q, busy_d;
  logic                             phase_q, phase_d;
  logic                             done_q, done_d;
  logic [hbe_pkg::STEP_W-1:0]       bit_q, bit_d;
  logic [W-1:0]                     rem_q, rem_d;
  logic [hbe_pkg::NBIN_W-1:0]       quot_q, quot_d;
  logic [W-1:0]                     d_q, d_d;
  logic [W-1:0]                     w_q, w_d;
  logic [hbe_pkg::NBIN_W-1:0]       n_q, n_d;

  logic [W:0] dbl, dbl_sub, sum, sum_sub;
  logic       dbl_ge, sum_ge;

  always_comb begin
    dbl     = {rem_q, 1'b0};
    dbl_ge  = dbl >= {1'b0, w_q};
    dbl_sub = dbl - {1'b0, w_q};
    sum     = {1'b0, rem_q} + {1'b0, d_q};
    sum_ge  = sum >= {1'b0, w_q};
    sum_sub = sum - {1'b0, w_q};
  end

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    done_d  = 1'b0;
    bit_d   = bit_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    d_d     = d_q;
    w_d     = w_q;
    n_d     = n_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      bit_d   = hbe_pkg::STEP_W'(hbe_pkg::NBIN_W - 1);
      rem_d   = '0;
      quot_d  = '0;
      d_d     = dividend_i;
      w_d     = span_i;
      n_d     = bins_i;
    end else if (busy_q) begin
      if (!phase_q) begin
        rem_d   = dbl_ge ? dbl_sub[W-1:0] : dbl[W-1:0];
        quot_d  = {quot_q[hbe_pkg::NBIN_W-2:0], dbl_ge};
        phase_d = 1'b1;
      end else begin
        if (n_q[bit_q]) begin
          rem_d  = sum_ge ? sum_sub[W-1:0] : sum[W-1:0];
          quot_d = quot_q + hbe_pkg::NBIN_W'(sum_ge);
        end
        phase_d = 1'b0;
        if (bit_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      bit_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      done_q  <= done_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    d_q    <= d_d;
    w_q    <= w_d;
    n_q    <= n_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### design/hbe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbe_checker
// Port-level checks of the histogram binning engine, bound to the top level.
// ----------------------------------------------------------------------------
module hbe_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input hbe_pkg::out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  a_no_bin_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == hbe_pkg::STAT_UNDER ||
                    out_item_o.status == hbe_pkg::STAT_OVER ||
                    out_item_o.status == hbe_pkg::STAT_CLEAR)
    |-> out_item_o.bin_number == '0 && out_item_o.bin_count == '0)
    else $error("bin fields set on a result without a bin");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == hbe_pkg::STAT_CLEAR
    |-> out_item_o.underflow_count == '0 && out_item_o.overflow_count == '0)
    else $error("counters not zero after clear");

  a_under_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == hbe_pkg::STAT_UNDER
    |-> out_item_o.underflow_count != '0)
    else $error("underflow result without underflow count");

  a_binned_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == hbe_pkg::STAT_BINNED
    |-> out_item_o.bin_count != '0)
    else $error("binned result with zero bin count");

endmodule

bind histogram_binning_engine_top hbe_checker u_hbe_checker (.*);

### tb/histogram_binning_engine_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_binning_engine_top_test
// Self-checking bench for the uniform-bin histogram engine. A directed table
// covers reset state, equal and swapped limits, field extremes, the dropped
// command and stale counts after a limit change; random phases then vary
// limits and bin count while a local histogram predicts every result item.
// ----------------------------------------------------------------------------
module histogram_binning_engine_top_test;
  import hbe_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int SETTLE_CYCLES   = 32;
  localparam int QUIET_LIMIT     = 6000;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 48;
  localparam logic [SAMPLE_WIDTH-1:0] SMP_MIN = 32'h8000_0000;
  localparam logic [SAMPLE_WIDTH-1:0] SMP_MAX = 32'h7FFF_FFFF;

  typedef struct {
    bit          is_write;
    bit          typed;
    in_item_t    item;
    out_item_t   want;
    logic [1:0]  reg_sel;
    logic [31:0] reg_val;
  } plan_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_item_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [PADDR_W-1:0]  paddr       = '0;
  logic [PDATA_W-1:0]  pwdata      = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  histogram_binning_engine_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  logic signed [SAMPLE_WIDTH-1:0] lim_a    = '0;
  logic signed [SAMPLE_WIDTH-1:0] lim_b    = '0;
  logic [CFG_BIN_W-1:0]           bins_cfg = 11'd1;
  logic [COUNT_WIDTH-1:0]         bin_tally [MAX_BINS];
  logic [COUNT_WIDTH-1:0]         under_tally = '0;
  logic [COUNT_WIDTH-1:0]         over_tally  = '0;
  logic [IDX_W-1:0]               last_bin    = '0;
  logic [SAMPLE_WIDTH-1:0]        last_sample = '0;

  out_item_t   awaited_results [$];
  plan_row_t   plan [$];
  bit          typed_pending = 1'b0;
  out_item_t   typed_want    = '0;
  int          mismatch_cnt  = 0;
  int          send_gap_pct  = 21;
  int          recv_stall_pct = 69;

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
    if (c == {COUNT_WIDTH{1'b1}}) return c;
    return c + 1'b1;
  endfunction

  function automatic bit tally_command(input in_item_t it, output out_item_t res);
    logic signed [SAMPLE_WIDTH-1:0] lo;
    logic signed [SAMPLE_WIDTH-1:0] hi;
    longint span;
    longint offs;
    longint n;
    longint idx;
    res = '0;
    lo = (lim_a < lim_b) ? lim_a : lim_b;
    hi = (lim_a < lim_b) ? lim_b : lim_a;
    n = (bins_cfg == 0) ? 1 : ((bins_cfg > MAX_BINS) ? MAX_BINS : bins_cfg);
    case (it.cmd)
      CMD_ADD: begin
        if (it.sample < lo) begin
          under_tally = bump(under_tally);
          res.status = STAT_UNDER;
        end else if (it.sample >= hi) begin
          over_tally = bump(over_tally);
          res.status = STAT_OVER;
        end else begin
          span = longint'(hi) - longint'(lo);
          offs = longint'(it.sample) - longint'(lo);
          idx = offs * n / span;
          if (idx >= n) idx = n - 1;
          bin_tally[idx] = bump(bin_tally[idx]);
          res.status = STAT_BINNED;
          res.bin_number = idx[IDX_W-1:0];
          res.bin_count = bin_tally[idx];
          last_bin = idx[IDX_W-1:0];
        end
      end
      CMD_READ: begin
        res.status = STAT_READ;
        res.bin_number = it.read_index;
        res.bin_count = bin_tally[it.read_index];
      end
      CMD_CLEAR: begin
        foreach (bin_tally[k]) bin_tally[k] = '0;
        under_tally = '0;
        over_tally = '0;
        res.status = STAT_CLEAR;
      end
      default: return 1'b0;
    endcase
    res.underflow_count = under_tally;
    res.overflow_count = over_tally;
    return 1'b1;
  endfunction

  task automatic check_field(input string field, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : score_results
    out_item_t predicted;
    out_item_t head;
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (tally_command(in_item_i, predicted))
        awaited_results.push_back(typed_pending ? typed_want : predicted);
      typed_pending = 1'b0;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("%0t: result item with none awaited", $time);
      end else begin
        head = awaited_results.pop_front();
        check_field("status", head.status, out_item_o.status);
        check_field("bin_number", head.bin_number, out_item_o.bin_number);
        check_field("bin_count", head.bin_count, out_item_o.bin_count);
        check_field("underflow_count", head.underflow_count, out_item_o.underflow_count);
        check_field("overflow_count", head.overflow_count, out_item_o.overflow_count);
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic send(input in_item_t it, input bit typed, input out_item_t want);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i = it;
    typed_pending = typed;
    typed_want = want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_and_settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] sel, input logic [PDATA_W-1:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {sel, 2'b00};
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (sel)
      REG_LOW:  lim_a = val;
      REG_HIGH: lim_b = val;
      REG_BINS: bins_cfg = val[CFG_BIN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic void plan_item(input logic [CMD_W-1:0] cmd,
                                    input logic [SAMPLE_WIDTH-1:0] smp,
                                    input logic [IDX_W-1:0] idx);
    plan_row_t row;
    row = '{default: '0};
    row.item.cmd = cmd;
    row.item.sample = smp;
    row.item.read_index = idx;
    plan.push_back(row);
  endfunction

  function automatic void plan_typed(input logic [CMD_W-1:0] cmd,
                                     input logic [SAMPLE_WIDTH-1:0] smp,
                                     input logic [IDX_W-1:0] idx,
                                     input logic [STATUS_W-1:0] st,
                                     input logic [IDX_W-1:0] num,
                                     input logic [COUNT_WIDTH-1:0] cnt,
                                     input logic [COUNT_WIDTH-1:0] unders,
                                     input logic [COUNT_WIDTH-1:0] overs);
    plan_row_t row;
    row = '{default: '0};
    row.typed = 1'b1;
    row.item.cmd = cmd;
    row.item.sample = smp;
    row.item.read_index = idx;
    row.want.status = st;
    row.want.bin_number = num;
    row.want.bin_count = cnt;
    row.want.underflow_count = unders;
    row.want.overflow_count = overs;
    plan.push_back(row);
  endfunction

  function automatic void plan_write(input logic [1:0] sel, input logic [31:0] val);
    plan_row_t row;
    row = '{default: '0};
    row.is_write = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    plan.push_back(row);
  endfunction

  function automatic in_item_t random_command();
    in_item_t it;
    logic signed [SAMPLE_WIDTH-1:0] lo;
    logic signed [SAMPLE_WIDTH-1:0] hi;
    longint span;
    longint pick;
    int r;
    lo = (lim_a < lim_b) ? lim_a : lim_b;
    hi = (lim_a < lim_b) ? lim_b : lim_a;
    span = longint'(hi) - longint'(lo);
    it.cmd = CMD_ADD;
    it.sample = $urandom;
    it.read_index = IDX_W'($urandom);
    r = $urandom_range(99);
    if (r < 55) begin
      if (span > 0) begin
        pick = longint'({$urandom, $urandom} % longint'(span));
        it.sample = SAMPLE_WIDTH'(longint'(lo) + pick);
        last_sample = it.sample;
      end
    end else if (r < 63) begin
      case ($urandom_range(3))
        0: pick = longint'(lo);
        1: pick = (span > 0) ? longint'(hi) - 1 : longint'(hi);
        2: pick = longint'(hi);
        default: pick = (lo == SMP_MIN) ? longint'(lo) : longint'(lo) - 1;
      endcase
      it.sample = SAMPLE_WIDTH'(pick);
    end else if (r < 70) begin
      it.sample = last_sample;
    end else if (r < 75) begin
      it.cmd = CMD_ADD;
    end else if (r < 90) begin
      it.cmd = CMD_READ;
      if ($urandom_range(1)) it.read_index = last_bin;
    end else if (r < 93) begin
      it.cmd = CMD_CLEAR;
    end else begin
      it.cmd = CMD_NONE;
    end
    return it;
  endfunction

  task automatic configure_phase(input int p);
    logic [31:0] a;
    logic [31:0] b;
    logic [CFG_BIN_W-1:0] n;
    in_item_t it;
    a = $urandom;
    b = $urandom;
    n = CFG_BIN_W'($urandom_range(1024));
    case (p)
      0: begin a = SMP_MIN; b = SMP_MAX; n = CFG_BIN_W'(1024); end
      1: begin a = 1000; b = -1000; n = '0; end
      3: begin a = 5; b = 5; n = CFG_BIN_W'(17); end
      4: begin a = -8; b = 8; n = CFG_BIN_W'(1024); end
      5: n = CFG_BIN_W'(2047);
      6: begin a = SMP_MAX; b = SMP_MIN; n = CFG_BIN_W'(1); end
      7: begin
        b = a + $urandom_range(1, 100000);
        n = CFG_BIN_W'($urandom_range(1, 64));
      end
      default: ;
    endcase
    drain_and_settle();
    apb_write(REG_LOW, a);
    apb_write(REG_HIGH, b);
    apb_write(REG_BINS, {{(PDATA_W-CFG_BIN_W){1'b0}}, n});
    if ($urandom_range(1)) begin
      it.cmd = CMD_CLEAR;
      it.sample = $urandom;
      it.read_index = IDX_W'($urandom);
      send(it, 1'b0, '0);
    end
  endtask

  initial begin
    in_item_t it;
    int sent;
    foreach (bin_tally[k]) bin_tally[k] = '0;

    plan_typed(CMD_READ, 32'd0, 10'd0, STAT_READ, 10'd0, 32'd0, 32'd0, 32'd0);
    plan_typed(CMD_READ, 32'd0, 10'd1023, STAT_READ, 10'd1023, 32'd0, 32'd0, 32'd0);
    plan_typed(CMD_ADD, 32'd0, 10'd0, STAT_OVER, 10'd0, 32'd0, 32'd0, 32'd1);
    plan_typed(CMD_ADD, 32'hFFFF_FFFF, 10'd0, STAT_UNDER, 10'd0, 32'd0, 32'd1, 32'd1);
    plan_typed(CMD_ADD, SMP_MAX, 10'd0, STAT_OVER, 10'd0, 32'd0, 32'd1, 32'd2);
    plan_typed(CMD_ADD, SMP_MIN, 10'd0, STAT_UNDER, 10'd0, 32'd0, 32'd2, 32'd2);
    plan_item(CMD_NONE, 32'hFFFF_FFFF, 10'd1023);
    plan_typed(CMD_READ, 32'd0, 10'd0, STAT_READ, 10'd0, 32'd0, 32'd2, 32'd2);
    plan_typed(CMD_CLEAR, 32'd0, 10'd0, STAT_CLEAR, 10'd0, 32'd0, 32'd0, 32'd0);
    plan_write(REG_LOW, SMP_MIN);
    plan_write(REG_HIGH, SMP_MAX);
    plan_write(REG_BINS, 32'd1024);
    plan_typed(CMD_ADD, SMP_MIN, 10'd0, STAT_BINNED, 10'd0, 32'd1, 32'd0, 32'd0);
    plan_typed(CMD_ADD, SMP_MAX, 10'd0, STAT_OVER, 10'd0, 32'd0, 32'd0, 32'd1);
    plan_item(CMD_ADD, 32'h7FFF_FFFE, 10'd0);
    plan_item(CMD_ADD, 32'd0, 10'd0);
    plan_item(CMD_READ, 32'd0, 10'd512);
    plan_write(REG_LOW, 32'd1000);
    plan_write(REG_HIGH, -32'sd1000);
    plan_write(REG_BINS, 32'd0);
    plan_item(CMD_ADD, -32'sd1000, 10'd0);
    plan_item(CMD_ADD, 32'd999, 10'd0);
    plan_item(CMD_ADD, 32'd1000, 10'd0);
    plan_item(CMD_ADD, -32'sd1001, 10'd0);
    plan_item(CMD_READ, 32'd0, 10'd0);
    plan_item(CMD_READ, 32'd0, 10'd1023);
    plan_typed(CMD_CLEAR, 32'd0, 10'd0, STAT_CLEAR, 10'd0, 32'd0, 32'd0, 32'd0);
    plan_typed(CMD_READ, 32'd0, 10'd1023, STAT_READ, 10'd1023, 32'd0, 32'd0, 32'd0);

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        drain_and_settle();
        apb_write(plan[i].reg_sel, plan[i].reg_val);
      end else begin
        send(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES / 3) begin
        send_gap_pct = 69;
        recv_stall_pct = 21;
      end else if (p == 2 * PHASES / 3) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      configure_phase(p);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        it = random_command();
        send(it, 1'b0, '0);
        if (it.cmd != CMD_NONE) sent++;
      end
    end

    drain_and_settle();
    if (mismatch_cnt == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
